/* hdl/eare_pkg.sv */
// ----------------------------------------------------------------------------
// eare_pkg: shared types and constants of the encoder angle rpm estimator
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package eare_pkg;

    // Default widths of the time stamp and the angle sample
    localparam int TIME_BITS_DEF  = 32;
    localparam int ANGLE_BITS_DEF = 12;

    // Register and result widths
    localparam int CFG_W = 16;
    localparam int RPM_W = 19;

    // Reset value of the minimum interval register
    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd50;

    // 60000 ms per minute times 256 for Q8
    localparam int Q8_MINUTE_W = 24;
    localparam logic [Q8_MINUTE_W-1:0] Q8_MINUTE = 24'd15360000;

    // Saturation limit of the speed in Q8 rpm
    localparam int RPM_LIMIT = 153600;

    // Divider: dividend is at most 7680000 (23 bits), divisor is a 24-bit time
    localparam int NUM_W = 23;
    localparam int DIV_W = 24;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the input beat and form elapsed time and angle change
        logic record;    // store angle and time as the new reference, set primed
        logic mark_upd;  // flag the item as producing a new estimate
        logic mul_load;  // form the dividend and load the divider
        logic div_step;  // one restoring division step
        logic fin;       // saturate, sign and store the new speed
        logic out_load;  // load the result beat into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic valid;      // captured sample was read correctly
        logic primed;     // a reference sample exists
        logic dt_ge_min;  // elapsed time reaches the minimum interval
        logic div_last;   // divider is on its final step
        logic out_free;   // output register can take a new beat
    } status_t;

endpackage

/* hdl/eare_ctrl.sv */
// ----------------------------------------------------------------------------
// eare_ctrl: sequencing controller of the encoder angle rpm estimator
// Takes one input beat at a time, steps the datapath through evaluation,
// multiplication and serial division, and hands the result to the output.
// ----------------------------------------------------------------------------
module eare_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  eare_pkg::status_t status,
    output eare_pkg::cmd_t    cmd
);

    eare_pkg::state_t state_reg;
    eare_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eare_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            eare_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = eare_pkg::ST_EVAL;
                end
            end
            eare_pkg::ST_EVAL:
            begin
                if (!status.valid)
                begin
                    state_next = eare_pkg::ST_DONE;
                end
                else if (!status.primed)
                begin
                    cmd.record = 1'b1;
                    state_next = eare_pkg::ST_DONE;
                end
                else if (!status.dt_ge_min)
                begin
                    state_next = eare_pkg::ST_DONE;
                end
                else
                begin
                    cmd.record   = 1'b1;
                    cmd.mark_upd = 1'b1;
                    state_next   = eare_pkg::ST_MUL;
                end
            end
            eare_pkg::ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = eare_pkg::ST_DIV;
            end
            eare_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = eare_pkg::ST_FIN;
                end
            end
            eare_pkg::ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = eare_pkg::ST_DONE;
            end
            eare_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = eare_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eare_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/eare_dpath.sv */
// ----------------------------------------------------------------------------
// eare_dpath: datapath of the encoder angle rpm estimator
// Holds the reference sample, the held speed and the minimum interval, forms
// elapsed time and wrapped angle change, and runs a restoring divider.
// ----------------------------------------------------------------------------
module eare_dpath
#(
    parameter int TIME_BITS  = eare_pkg::TIME_BITS_DEF,
    parameter int ANGLE_BITS = eare_pkg::ANGLE_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  eare_pkg::cmd_t                   cmd,
    output eare_pkg::status_t                status,
    input  logic [TIME_BITS-1:0]             now_ms,
    input  logic [ANGLE_BITS-1:0]            angle,
    input  logic                             angle_valid,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [eare_pkg::CFG_W-1:0]       cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [eare_pkg::RPM_W-1:0] rpm_q8,
    output logic                             updated
);

    localparam int AW2    = ANGLE_BITS + 2;
    localparam int PROD_W = ANGLE_BITS + eare_pkg::Q8_MINUTE_W;
    localparam logic signed [AW2-1:0] A_HALF = AW2'(1) << (ANGLE_BITS - 1);
    localparam logic signed [AW2-1:0] A_FULL = AW2'(1) << ANGLE_BITS;

    // State with a defined reset
    logic [eare_pkg::CFG_W-1:0]        min_interval_reg, min_interval_next;
    logic [ANGLE_BITS-1:0]             prev_angle_reg, prev_angle_next;
    logic [TIME_BITS-1:0]              last_time_reg, last_time_next;
    logic signed [eare_pkg::RPM_W-1:0] held_speed_reg, held_speed_next;
    logic                              primed_reg, primed_next;
    logic                              out_valid_reg, out_valid_next;
    logic [eare_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    // Working payload
    logic [TIME_BITS-1:0]              now_reg, now_next;
    logic [ANGLE_BITS-1:0]             angle_reg, angle_next;
    logic                              valid_reg, valid_next;
    logic [TIME_BITS-1:0]              dt_reg, dt_next;
    logic signed [ANGLE_BITS:0]        diff_reg, diff_next;
    logic                              upd_reg, upd_next;
    logic [eare_pkg::NUM_W-1:0]        num_reg, num_next;
    logic [eare_pkg::DIV_W-1:0]        rem_reg, rem_next;
    logic [eare_pkg::DIV_W-1:0]        dvs_reg, dvs_next;
    logic signed [eare_pkg::RPM_W-1:0] rpm_q8_reg, rpm_q8_next;
    logic                              updated_reg, updated_next;

    // Combinational helpers
    logic signed [AW2-1:0]             raw_diff;
    logic signed [AW2-1:0]             wrap_diff;
    logic                              neg;
    logic [ANGLE_BITS:0]               mag_full;
    logic [ANGLE_BITS-1:0]             mag;
    logic [PROD_W-1:0]                 prod;
    logic [eare_pkg::DIV_W:0]          trial;
    logic [eare_pkg::DIV_W:0]          trial_sub;
    logic                              mag_zero;
    logic                              dt_big;
    logic [eare_pkg::NUM_W-1:0]        quot;
    logic [eare_pkg::RPM_W-1:0]        spd_mag;

    // Wrap the angle change into half a revolution either way
    always_comb
    begin
        raw_diff  = $signed({2'b00, angle}) - $signed({2'b00, prev_angle_reg});
        wrap_diff = raw_diff;
        if (raw_diff > A_HALF)
        begin
            wrap_diff = raw_diff - A_FULL;
        end
        else if (raw_diff < -A_HALF)
        begin
            wrap_diff = raw_diff + A_FULL;
        end
    end

    // Magnitude, dividend product and divider trial
    always_comb
    begin
        neg       = diff_reg[ANGLE_BITS];
        mag_full  = neg ? (ANGLE_BITS+1)'(-diff_reg) : (ANGLE_BITS+1)'(diff_reg);
        mag       = mag_full[ANGLE_BITS-1:0];
        prod      = PROD_W'(mag) * PROD_W'(eare_pkg::Q8_MINUTE);
        trial     = {rem_reg, num_reg[eare_pkg::NUM_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        mag_zero  = (mag == '0);
        dt_big    = ((dt_reg >> eare_pkg::DIV_W) != '0);
    end

    // Saturate the quotient, or force it to zero for no angle change or a too long elapsed time
    always_comb
    begin
        quot = num_reg;
        if (mag_zero || dt_big)
        begin
            quot = '0;
        end
        else if (num_reg > eare_pkg::NUM_W'(eare_pkg::RPM_LIMIT))
        begin
            quot = eare_pkg::NUM_W'(eare_pkg::RPM_LIMIT);
        end
        spd_mag = eare_pkg::RPM_W'(quot);
    end

    // Next values
    always_comb
    begin
        min_interval_next = min_interval_reg;
        prev_angle_next   = prev_angle_reg;
        last_time_next    = last_time_reg;
        held_speed_next   = held_speed_reg;
        primed_next       = primed_reg;
        out_valid_next    = out_valid_reg;
        cnt_next          = cnt_reg;
        now_next          = now_reg;
        angle_next        = angle_reg;
        valid_next        = valid_reg;
        dt_next           = dt_reg;
        diff_next         = diff_reg;
        upd_next          = upd_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        rpm_q8_next       = rpm_q8_reg;
        updated_next      = updated_reg;

        // Take the configuration beat
        if (cfg_valid)
        begin
            min_interval_next = cfg_data;
        end

        // Capture the input beat with elapsed time and angle change
        if (cmd.capture)
        begin
            now_next   = now_ms;
            angle_next = angle;
            valid_next = angle_valid;
            dt_next    = now_ms - last_time_reg;
            diff_next  = wrap_diff[ANGLE_BITS:0];
            upd_next   = 1'b0;
        end

        // Advance the reference sample
        if (cmd.record)
        begin
            prev_angle_next = angle_reg;
            last_time_next  = now_reg;
            primed_next     = 1'b1;
        end

        if (cmd.mark_upd)
        begin
            upd_next = 1'b1;
        end

        // Load the divider
        if (cmd.mul_load)
        begin
            num_next = eare_pkg::NUM_W'(prod >> ANGLE_BITS);
            rem_next = '0;
            dvs_next = eare_pkg::DIV_W'(dt_reg);
            cnt_next = eare_pkg::CNT_W'(eare_pkg::NUM_W - 1);
        end

        // One restoring step: shift in a dividend bit, subtract when it fits
        if (cmd.div_step)
        begin
            if (!trial_sub[eare_pkg::DIV_W])
            begin
                rem_next = trial_sub[eare_pkg::DIV_W-1:0];
                num_next = {num_reg[eare_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[eare_pkg::DIV_W-1:0];
                num_next = {num_reg[eare_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end

        // Hold the new speed
        if (cmd.fin)
        begin
            held_speed_next = neg ? -$signed(spd_mag) : $signed(spd_mag);
        end

        // Drop the output beat once taken, load the next one
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            rpm_q8_next    = held_speed_reg;
            updated_next   = upd_reg;
        end
    end

    // Control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= eare_pkg::MIN_INTERVAL_RST;
            prev_angle_reg   <= '0;
            last_time_reg    <= '0;
            held_speed_reg   <= '0;
            primed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            min_interval_reg <= min_interval_next;
            prev_angle_reg   <= prev_angle_next;
            last_time_reg    <= last_time_next;
            held_speed_reg   <= held_speed_next;
            primed_reg       <= primed_next;
            out_valid_reg    <= out_valid_next;
            cnt_reg          <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        angle_reg   <= angle_next;
        valid_reg   <= valid_next;
        dt_reg      <= dt_next;
        diff_reg    <= diff_next;
        upd_reg     <= upd_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        rpm_q8_reg  <= rpm_q8_next;
        updated_reg <= updated_next;
    end

    // Status to the controller
    always_comb
    begin
        status.valid     = valid_reg;
        status.primed    = primed_reg;
        status.dt_ge_min = (dt_reg >= TIME_BITS'(min_interval_reg));
        status.div_last  = (cnt_reg == '0);
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign rpm_q8    = rpm_q8_reg;
    assign updated   = updated_reg;

endmodule

/* hdl/encoder_angle_rpm_estimator_unit.sv */
// ----------------------------------------------------------------------------
// encoder_angle_rpm_estimator_unit: speed of one wheel from absolute angle
// Turns millisecond-stamped absolute angle samples into a signed Q8 rpm
// estimate using a wrapped angle change and a serial divider.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready) carries now_ms, angle and angle_valid.
//   Output channel (out_valid/out_ready) returns one beat per input beat:
//   rpm_q8 and updated. Configuration channel (cfg_valid/cfg_ready, cfg_data)
//   writes min_interval_ms; cfg_ready is always high. Write it while idle.
//   One sample is worked on at a time; in_ready is high only when the
//   controller is idle.
//   A sample that gives a new estimate goes through evaluation, multiply,
//   23 one-bit steps of the restoring divider, saturation and output load
//   before out_valid; other samples go from evaluation straight to the
//   output load. The next sample is taken only after that output load.
//   The output register holds a finished beat while the receiver stalls; the
//   next sample is still accepted and worked on, and waits to load until the
//   output beat is taken.
//   Reset clears the reference sample, held speed and primed flag, sets the
//   minimum interval to 50 ms and empties the output register.
// ----------------------------------------------------------------------------
module encoder_angle_rpm_estimator_unit
#(
    parameter int TIME_BITS  = eare_pkg::TIME_BITS_DEF,
    parameter int ANGLE_BITS = eare_pkg::ANGLE_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [TIME_BITS-1:0]              now_ms,
    input  logic [ANGLE_BITS-1:0]             angle,
    input  logic                              angle_valid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [eare_pkg::CFG_W-1:0]        cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [eare_pkg::RPM_W-1:0] rpm_q8,
    output logic                              updated
);

    eare_pkg::cmd_t    cmd;
    eare_pkg::status_t status;

    eare_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    eare_dpath
    #(
        .TIME_BITS  (TIME_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .now_ms      (now_ms),
        .angle       (angle),
        .angle_valid (angle_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rpm_q8      (rpm_q8),
        .updated     (updated)
    );

    // One sample at a time: no new beat straight after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a sample is in work");

    // A result is loaded only into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("output beat overwritten");

    // The divider runs only while the input side is closed
    a_div_closed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (!in_ready && !cmd.out_load))
        else $error("divider step outside a busy sample");

    // A delivered speed stays inside the saturation limits
    a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rpm_q8 <= $signed(eare_pkg::RPM_W'(eare_pkg::RPM_LIMIT))
                       && rpm_q8 >= -$signed(eare_pkg::RPM_W'(eare_pkg::RPM_LIMIT))))
        else $error("speed beyond saturation limit");

endmodule

/* bench/speed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_checker: result checker for the encoder angle rpm estimator
// Watches the input, configuration and output channels of the block. Keeps
// its own copy of the reference sample, held speed and minimum interval,
// works out the result beat of every accepted sample and compares each
// accepted output beat, field by field, with the oldest outstanding estimate.
// ----------------------------------------------------------------------------
module speed_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [eare_pkg::TIME_BITS_DEF-1:0]    now_ms,
    input  logic [eare_pkg::ANGLE_BITS_DEF-1:0]   angle,
    input  logic                                  angle_valid,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [eare_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [eare_pkg::RPM_W-1:0]     rpm_q8,
    input  logic                                  updated,
    output int                                    fail_count,
    output int                                    pending
);

    localparam int TB = eare_pkg::TIME_BITS_DEF;
    localparam int AB = eare_pkg::ANGLE_BITS_DEF;
    localparam int RW = eare_pkg::RPM_W;

    // Q8 rpm from counts per millisecond: 60000 ms per minute, 256 per rpm
    localparam longint unsigned Q8_PER_MIN = 64'd60000 * 64'd256;
    localparam longint          TURN       = longint'(1) << AB;
    localparam longint          HALF_TURN  = longint'(1) << (AB - 1);

    typedef struct packed {
        logic signed [RW-1:0] rpm;
        logic                 upd;
    } speed_beat_t;

    speed_beat_t                 expected_speeds[$];
    logic [AB-1:0]               ref_angle;
    logic [TB-1:0]               ref_time;
    logic signed [RW-1:0]        held_rpm;
    logic                        have_ref;
    logic [eare_pkg::CFG_W-1:0]  min_gap;
    int                          errs;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        errs       = 0;
    end

    // Speed in Q8 rpm from a wrapped angle change and an elapsed time
    function automatic logic signed [RW-1:0] rpm_of(input longint diff,
                                                    input longint unsigned dt);
        longint unsigned mag;
        longint unsigned q;
        longint          r;
        mag = (diff < 0) ? -diff : diff;
        if (mag == 0)
            return '0;
        if (dt == 0)
            q = 64'(eare_pkg::RPM_LIMIT);
        else if (dt >= (64'd1 << 24))
            q = 0;
        else
        begin
            q = (mag * Q8_PER_MIN) / (dt << AB);
            if (q > 64'(eare_pkg::RPM_LIMIT))
                q = 64'(eare_pkg::RPM_LIMIT);
        end
        r = (diff < 0) ? -longint'(q) : longint'(q);
        return r[RW-1:0];
    endfunction

    // Advance the estimator copy by one sample and return its result beat
    function automatic speed_beat_t step_estimate(input logic [TB-1:0] t,
                                                  input logic [AB-1:0] a,
                                                  input logic          ok);
        speed_beat_t   b;
        logic [TB-1:0] dt;
        longint        diff;
        b.upd = 1'b0;
        if (ok && !have_ref)
        begin
            ref_angle = a;
            ref_time  = t;
            have_ref  = 1'b1;
        end
        else if (ok)
        begin
            dt = t - ref_time;
            if (dt >= min_gap)
            begin
                diff = $signed({1'b0, a}) - $signed({1'b0, ref_angle});
                if (diff > HALF_TURN)
                    diff -= TURN;
                else if (diff < -HALF_TURN)
                    diff += TURN;
                held_rpm  = rpm_of(diff, dt);
                ref_angle = a;
                ref_time  = t;
                b.upd     = 1'b1;
            end
        end
        b.rpm = held_rpm;
        return b;
    endfunction

    // Track the channels, predict on each input beat, check each output beat
    always @(posedge clk or negedge rst_n)
    begin
        speed_beat_t want;
        if (!rst_n)
        begin
            ref_angle = '0;
            ref_time  = '0;
            held_rpm  = '0;
            have_ref  = 1'b0;
            min_gap   = eare_pkg::MIN_INTERVAL_RST;
            expected_speeds.delete();
            pending  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                min_gap = cfg_data;

            if (out_valid && out_ready)
            begin
                if (expected_speeds.size() == 0)
                begin
                    $error("unexpected result beat: rpm_q8 %0d, updated %0b",
                           rpm_q8, updated);
                    errs++;
                end
                else
                begin
                    want = expected_speeds.pop_front();
                    if (rpm_q8 !== want.rpm)
                    begin
                        $error("rpm_q8: expected %0d, actual %0d",
                               $signed(want.rpm), rpm_q8);
                        errs++;
                    end
                    if (updated !== want.upd)
                    begin
                        $error("updated: expected %0b, actual %0b", want.upd, updated);
                        errs++;
                    end
                end
            end

            if (in_valid && in_ready)
                expected_speeds.push_back(step_estimate(now_ms, angle, angle_valid));

            pending <= expected_speeds.size();
        end
        fail_count <= errs;
    end

endmodule

/* bench/encoder_angle_rpm_estimator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_angle_rpm_estimator_unit_tb: testbench of the rpm estimator
// Drives directed samples over the special cases (first sample, read
// failures, interval edges, angle wrap, saturation, zero and very long
// elapsed time, time stamp wrap), then phases of random sample tracks under
// several minimum interval settings, with random idling on both channels,
// a long output stall and a full drain. Results are checked beside the block.
// ----------------------------------------------------------------------------
module encoder_angle_rpm_estimator_unit_tb;

    localparam int TW = eare_pkg::TIME_BITS_DEF;
    localparam int AW = eare_pkg::ANGLE_BITS_DEF;
    localparam int CW = eare_pkg::CFG_W;

    logic                               clk;
    logic                               rst_n       = 1'b0;
    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    logic [TW-1:0]                      now_ms      = '0;
    logic [AW-1:0]                      angle       = '0;
    logic                               angle_valid = 1'b0;
    logic                               cfg_valid   = 1'b0;
    logic                               cfg_ready;
    logic [CW-1:0]                      cfg_data    = '0;
    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic signed [eare_pkg::RPM_W-1:0]  rpm_q8;
    logic                               updated;

    int                                 fail_count;
    int                                 pending;
    bit                                 calm     = 1'b0;
    bit                                 hold_req = 1'b0;
    logic [TW-1:0]                      track_time;
    logic [AW-1:0]                      track_angle;
    logic [CW-1:0]                      cur_min = eare_pkg::MIN_INTERVAL_RST;

    encoder_angle_rpm_estimator_unit i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .angle       (angle),
        .angle_valid (angle_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rpm_q8      (rpm_q8),
        .updated     (updated)
    );

    speed_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .angle       (angle),
        .angle_valid (angle_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rpm_q8      (rpm_q8),
        .updated     (updated),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 95)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = 400;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one sample beat and hold it until accepted
    task automatic send_beat(input logic [TW-1:0] t,
                             input logic [AW-1:0] a,
                             input logic          ok);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 1) == 1) ? pick_gap() : 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        now_ms      <= t;
        angle       <= a;
        angle_valid <= ok;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop the input and wait until every outstanding result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Write the minimum interval once the block is idle
    task automatic set_min_interval(input logic [CW-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_min = v;
    endtask

    // One random sample: mostly a plausible track, some noise and failures
    task automatic random_sample();
        int            r;
        logic [TW-1:0] step;
        logic [AW-1:0] delta;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            track_time  = TW'($urandom);
            track_angle = AW'($urandom);
            send_beat(track_time, track_angle, 1'($urandom_range(0, 1)));
        end
        else if (r < 15)
        begin
            track_time += TW'($urandom_range(0, 2 * cur_min + 10));
            send_beat(track_time, AW'($urandom), 1'b0);
        end
        else
        begin
            if (r < 80)
                step = TW'(cur_min + $urandom_range(0, 3 * cur_min + 20));
            else if (r < 95)
                step = TW'($urandom_range(0, cur_min));
            else
                step = TW'($urandom);
            if ($urandom_range(0, 1) == 1)
                delta = AW'($urandom_range(0, 255) - 128);
            else
                delta = AW'($urandom);
            track_time  += step;
            track_angle += delta;
            send_beat(track_time, track_angle, 1'b1);
        end
    endtask

    // One setting of the interval with a run of random samples
    task automatic run_phase(input logic [CW-1:0] v, input int n, input bit quiet,
                             input int hold_at, input int pause_at);
        set_min_interval(v);
        calm = quiet;
        for (int i = 0; i < n; i++)
        begin
            // stall the output for a long stretch while samples keep coming
            if (i == hold_at)
            begin
                hold_req = 1'b1;
                calm     = 1'b1;
            end
            if (i == pause_at)
                drain();
            random_sample();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default interval of 50 ms
        send_beat(32'd100, 12'd7, 1'b0);                // read failure before any sample
        send_beat(32'd5, 12'd4095, 1'b1);               // first sample only records
        send_beat(32'd30, 12'd0, 1'b1);                 // interval not reached
        send_beat(32'd55, 12'd0, 1'b1);                 // change wraps to +1
        send_beat(32'd155, 12'd2048, 1'b1);             // half turn forward
        send_beat(32'd255, 12'd0, 1'b1);                // half turn back
        send_beat(32'd2000, 12'd77, 1'b0);              // read failure holds speed
        send_beat(32'd305, 12'd2048, 1'b1);             // exactly at the limit
        send_beat(32'd305 + (32'd1 << 24), 12'd100, 1'b1); // very long elapsed time
        send_beat(32'hFFFF_FFF0, 12'd4000, 1'b1);
        send_beat(32'h0000_0040, 12'd400, 1'b1);        // time stamp wraps
        send_beat(32'hFFFF_FFFF, 12'd4095, 1'b1);

        // Directed: zero interval, zero elapsed time and saturation
        set_min_interval(16'd0);
        send_beat(32'hFFFF_FFFF, 12'd4095, 1'b1);
        send_beat(32'hFFFF_FFFF, 12'd4094, 1'b1);
        send_beat(32'hFFFF_FFFF, 12'd4095, 1'b1);
        send_beat(32'h0000_0000, 12'd3095, 1'b1);
        send_beat(32'h0000_0000, 12'hFFF, 1'b0);

        // Directed: largest interval, just below and at it
        set_min_interval(16'hFFFF);
        send_beat(32'd65534, 12'd5, 1'b1);
        send_beat(32'd65535, 12'd5, 1'b1);
        send_beat(32'd131070, 12'd1030, 1'b1);

        track_time  = 32'd131070;
        track_angle = 12'd1030;

        // Random phases over several settings
        run_phase(16'd50, 200, 1'b0, 80, -1);
        run_phase(16'd0, 80, 1'b0, -1, 40);
        run_phase(16'hFFFF, 50, 1'b0, -1, -1);
        run_phase(16'd1, 60, 1'b1, -1, -1);
        run_phase(CW'($urandom), 50, 1'b0, -1, -1);
        run_phase(16'd20, 120, 1'b0, -1, 60);
        run_phase(16'd200, 140, 1'b0, -1, -1);

        // Let the last beats out, then a quiet tail for stray beats
        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
